@@ design/bpfa_pkg.sv @@
// Shared types and constants for the bitmap page frame allocator.
package bpfa_pkg;

    localparam int ADDR_W     = 64;
    localparam int PCNT_W     = 13;
    localparam int WORD_W     = 64;
    localparam int BIT_IDX_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_MAP_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT        = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OOM   = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic    clr_step;
        logic    scan_start;
        logic    scan_step;
        logic    alloc_wr;
        logic    alloc_add;
        logic    alloc_sub;
        logic    free_load;
        logic    free_add;
        logic    free_sub;
        logic    div_start;
        logic    div_step;
        logic    free_wr;
        logic    res_set;
        logic    res_zero;
        t_status res_status;
        logic    out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic found;
        logic scan_done;
        logic in_range;
        logic div_last;
        logic out_busy;
    } t_sts;

endpackage

@@ design/bpfa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bpfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bpfa_ctrl.sv @@
// Sequencing state machine for the page allocator.
module bpfa_ctrl
    import bpfa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_command,
    input  t_sts i_sts,
    output logic o_req_ready,
    output t_cmd o_cmd
);

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_SCAN   = 13'b0000000000100,
        S_AWR    = 13'b0000000001000,
        S_AADD   = 13'b0000000010000,
        S_ASUB   = 13'b0000000100000,
        S_FADD   = 13'b0000001000000,
        S_FSUB   = 13'b0000010000000,
        S_FCMP   = 13'b0000100000000,
        S_FDIV   = 13'b0001000000000,
        S_FREAD  = 13'b0010000000000,
        S_FWRITE = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.res_status = ST_OK;
        o_req_ready      = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    if (i_command == CMD_FREE) begin
                        o_cmd.free_load = 1'b1;
                        n_state         = S_FADD;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.found) begin
                    n_state = S_AWR;
                end else if (i_sts.scan_done) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_zero   = 1'b1;
                    o_cmd.res_status = ST_OOM;
                    n_state          = S_DONE;
                end
            end
            S_AWR: begin
                o_cmd.alloc_wr = 1'b1;
                n_state        = S_AADD;
            end
            S_AADD: begin
                o_cmd.alloc_add = 1'b1;
                n_state         = S_ASUB;
            end
            S_ASUB: begin
                o_cmd.alloc_sub  = 1'b1;
                o_cmd.res_set    = 1'b1;
                o_cmd.res_status = ST_OK;
                n_state          = S_DONE;
            end
            S_FADD: begin
                o_cmd.free_add = 1'b1;
                n_state        = S_FSUB;
            end
            S_FSUB: begin
                o_cmd.free_sub = 1'b1;
                n_state        = S_FCMP;
            end
            S_FCMP: begin
                if (i_sts.in_range) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_FDIV;
                end else begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_zero   = 1'b1;
                    o_cmd.res_status = ST_RANGE;
                    n_state          = S_DONE;
                end
            end
            S_FDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FREAD;
                end
            end
            S_FREAD: begin
                // word address is driven from the quotient; data lands next cycle
                n_state = S_FWRITE;
            end
            S_FWRITE: begin
                o_cmd.free_wr    = 1'b1;
                o_cmd.res_set    = 1'b1;
                o_cmd.res_zero   = 1'b1;
                o_cmd.res_status = ST_OK;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_sts.out_busy)
        else $error("response register overwritten while held");

    a_ready_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) && !i_sts.clr_last |=> !o_req_ready)
        else $error("request taken before bitmap clear finished");

endmodule

@@ design/bpfa_dp.sv @@
// Datapath: config registers, bitmap RAM, scan, address math, divider, response register.
module bpfa_dp
    import bpfa_pkg::*;
#(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [ADDR_W-1:0]     i_free_address,
    input  logic                  i_rsp_ready,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_rsp_valid,
    output logic [ADDR_W-1:0]     o_page_address,
    output logic [1:0]            o_status
);

    localparam int WORDS = MAX_PAGES / 64;
    localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W = $clog2(WORDS + 1);
    localparam int QW    = $clog2(MAX_PAGES);
    localparam int LW    = $clog2(MAX_PAGES + 1);
    localparam int CMPW  = (LW > PCNT_W) ? LW : PCNT_W;
    localparam int PBW   = $clog2(PAGE_BYTES + 1);
    localparam longint unsigned SPAN = longint'(MAX_PAGES) * longint'(PAGE_BYTES);
    localparam int OW    = $clog2(SPAN);
    localparam int BW    = LW + PBW;
    localparam int PW    = PBW + QW;
    localparam logic [PBW-1:0] PB_C = PBW'(PAGE_BYTES);
    // reciprocal of the page size, scaled by 2^OW; estimate is low by at most one
    localparam longint unsigned RECIP = (longint'(1) << OW) / longint'(PAGE_BYTES);
    localparam int RW    = $clog2(RECIP + 1);
    localparam int MW    = OW + RW;
    localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
    localparam logic [OW-1:0] PB_REM  = OW'(PAGE_BYTES);
    // divider stages: estimate, back-multiply, correct
    localparam int KW    = 2;
    localparam logic [KW-1:0] DIV_EST = 2'd2;
    localparam logic [KW-1:0] DIV_MUL = 2'd1;

    function automatic logic [BIT_IDX_W:0] find_first(input logic [WORD_W-1:0] v);
        logic [7:0] any_b;
        logic [2:0] bsel;
        logic [7:0] byte_v;
        logic [2:0] isel;
        int         b;
        for (b = 0; b < 8; b++) begin
            any_b[b] = |v[8*b +: 8];
        end
        bsel = '0;
        for (b = 7; b >= 0; b--) begin
            if (any_b[b]) bsel = 3'(b);
        end
        byte_v = v[8*bsel +: 8];
        isel = '0;
        for (b = 7; b >= 0; b--) begin
            if (byte_v[b]) isel = 3'(b);
        end
        return {|any_b, bsel, isel};
    endfunction

    // config
    logic [ADDR_W-1:0] r_base, r_dmo;
    logic [PCNT_W-1:0] r_pcnt;
    // control
    logic [CNT_W-1:0]  r_cnt;
    logic              r_pend;
    logic              r_out_valid;
    // payload
    logic [WA-1:0]     r_chk;
    logic [QW-1:0]     r_hit;
    logic [WORD_W-1:0] r_wdata;
    logic [ADDR_W-1:0] r_acc;
    logic [BW-1:0]     r_bound;
    logic [OW-1:0]     r_rem;
    logic [PW-1:0]     r_qprod;
    logic [QW-1:0]     r_q;
    logic [KW-1:0]     r_k;
    t_status           r_res_status;
    logic              r_res_zero;
    logic [ADDR_W-1:0] r_out_addr;
    t_status           r_out_status;

    logic [LW-1:0]        w_limit;
    logic [CNT_W-1:0]     w_nwords;
    logic                 w_issue;
    logic                 w_partial;
    logic [WORD_W-1:0]    w_mask, w_cand, w_rdata, w_wdata;
    logic                 w_any, w_found;
    logic [BIT_IDX_W-1:0] w_bit;
    logic [QW-1:0]        w_page;
    logic [WA-1:0]        w_hit_word, w_q_word, w_waddr, w_raddr;
    logic                 w_we;
    logic [PW-1:0]        w_prod;
    logic [BW-1:0]        w_bnd;
    logic [MW-1:0]        w_rprod;
    logic [PW-1:0]        w_qprod;
    logic [OW-1:0]        w_resid;

    always_comb begin
        w_limit = (CMPW'(r_pcnt) < CMPW'(MAX_PAGES)) ? LW'(r_pcnt) : LW'(MAX_PAGES);
        w_nwords = CNT_W'(({1'b0, w_limit} + (LW + 1)'(63)) >> 6);
    end

    // scan: data of word r_chk is on the RAM output when r_pend is set
    assign w_issue   = r_cnt < w_nwords;
    assign w_partial = ((CNT_W'(r_chk) + CNT_W'(1)) == w_nwords)
                       && (w_limit[BIT_IDX_W-1:0] != '0);

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            w_mask[b] = !w_partial || (BIT_IDX_W'(b) < w_limit[BIT_IDX_W-1:0]);
        end
    end

    assign w_cand           = ~w_rdata & w_mask;
    assign {w_any, w_bit}   = find_first(w_cand);
    assign w_found          = r_pend && w_any;
    assign w_page           = QW'({r_chk, w_bit});

    assign w_hit_word = WA'(r_hit >> 6);
    assign w_q_word   = WA'(r_q >> 6);

    always_comb begin
        w_we = i_cmd.clr_step || i_cmd.alloc_wr || i_cmd.free_wr;
        priority if (i_cmd.clr_step) begin
            w_waddr = WA'(r_cnt);
            w_wdata = '0;
        end else if (i_cmd.alloc_wr) begin
            w_waddr = w_hit_word;
            w_wdata = r_wdata | (WORD_W'(1) << r_hit[BIT_IDX_W-1:0]);
        end else begin
            w_waddr = w_q_word;
            w_wdata = w_rdata & ~(WORD_W'(1) << r_q[BIT_IDX_W-1:0]);
        end
        w_raddr = i_cmd.scan_step ? WA'(r_cnt) : w_q_word;
    end

    bpfa_ram #(
        .WIDTH(WORD_W),
        .DEPTH(WORDS)
    ) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_prod  = PW'(PB_C) * PW'(r_hit);
    assign w_bnd   = BW'(w_limit) * BW'(PB_C);
    assign w_rprod = MW'(r_rem) * MW'(RECIP_C);
    assign w_qprod = PW'(PB_C) * PW'(r_q);
    assign w_resid = r_rem - OW'(r_qprod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_dmo       <= '0;
            r_pcnt      <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_REGION_BASE:       r_base <= i_cfg_data;
                    CFG_DIRECT_MAP_OFFSET: r_dmo  <= i_cfg_data;
                    CFG_PAGE_COUNT:        r_pcnt <= i_cfg_data[PCNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.scan_start) begin
                r_cnt <= '0;
            end else if (i_cmd.clr_step || (i_cmd.scan_step && w_issue)) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            r_pend <= i_cmd.scan_step && w_issue;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && w_issue) begin
            r_chk <= WA'(r_cnt);
        end
        if (w_found) begin
            r_hit   <= w_page;
            r_wdata <= w_rdata;
        end
        priority if (i_cmd.free_load) begin
            r_acc <= i_free_address;
        end else if (i_cmd.alloc_wr) begin
            r_acc <= ADDR_W'(w_prod);
        end else if (i_cmd.alloc_add) begin
            r_acc <= r_acc + r_base;
        end else if (i_cmd.alloc_sub) begin
            r_acc <= r_acc - r_dmo;
        end else if (i_cmd.free_add) begin
            r_acc <= r_acc + r_dmo;
        end else if (i_cmd.free_sub) begin
            r_acc <= r_acc - r_base;
        end
        if (i_cmd.free_add) begin
            r_bound <= w_bnd;
        end
        // divide by the page size: reciprocal estimate, back-multiply, one correction
        if (i_cmd.div_start) begin
            r_rem <= OW'(r_acc);
            r_k   <= DIV_EST;
        end else if (i_cmd.div_step) begin
            if (r_k == DIV_EST) begin
                r_q <= QW'(w_rprod >> OW);
            end else if (r_k == DIV_MUL) begin
                r_qprod <= w_qprod;
            end else if (w_resid >= PB_REM) begin
                r_q <= r_q + QW'(1);
            end
            r_k <= r_k - KW'(1);
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
            r_res_zero   <= i_cmd.res_zero;
        end
        if (i_cmd.out_load) begin
            r_out_addr   <= r_res_zero ? '0 : r_acc;
            r_out_status <= r_res_status;
        end
    end

    always_comb begin
        o_sts.clr_last  = r_cnt == CNT_W'(WORDS - 1);
        o_sts.found     = w_found;
        o_sts.scan_done = !r_pend && !w_issue;
        o_sts.in_range  = r_acc < ADDR_W'(r_bound);
        o_sts.div_last  = r_k == '0;
        o_sts.out_busy  = r_out_valid && !i_rsp_ready;
    end

    assign o_rsp_valid    = r_out_valid;
    assign o_page_address = r_out_addr;
    assign o_status       = r_out_status;

    a_chk_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (CNT_W'(r_chk) < w_nwords))
        else $error("checked word lies beyond the scanned range");

    a_hit_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_found |-> (LW'(w_page) < w_limit))
        else $error("allocated page not below page count");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && (r_k == '0)) |-> ({1'b0, w_resid} < ({1'b0, PB_REM} << 1)))
        else $error("divider estimate off by more than one");

endmodule

@@ design/bitmap_page_frame_allocator.sv @@
// Top level of the first-fit bitmap page frame allocator.
//
// Request channel (i_req_valid / o_req_ready): i_command selects allocate
// (CMD_ALLOC) or free (CMD_FREE); i_free_address is used by free only.
// Response channel (o_rsp_valid / i_rsp_ready): o_page_address and o_status
// (ok, out of memory, free address out of range). One response per request.
// Config port: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 region base, 1 direct-map offset, 2 page count); write only when idle.
//
// One request is in work at a time; the next can be taken in the same cycle
// that the response appears. Allocate reads the bitmap RAM one 64-bit word
// per cycle, up to ceil(min(page_count, MAX_PAGES)/64) words, and stops at the
// first word with a free page; out of memory when no word has one.
// Free does address math, a reciprocal multiply with one correction for the
// divide by PAGE_BYTES, and the read-modify-write of one bitmap word; an
// out-of-range address ends after the address math.
// After reset a clearing pass zeroes the bitmap one word at a time;
// o_req_ready stays low for that time, config writes are taken as usual.
// The response is held in an output register, so the next request is taken
// while it waits; a stalled receiver only holds the following completion.
module bitmap_page_frame_allocator
    import bpfa_pkg::*;
#(
    parameter int MAX_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  logic                  i_command,
    input  logic [ADDR_W-1:0]     i_free_address,
    // response
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    output logic [ADDR_W-1:0]     o_page_address,
    output logic [1:0]            o_status,
    // config
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    bpfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .i_command  (i_command),
        .i_sts      (w_sts),
        .o_req_ready(o_req_ready),
        .o_cmd      (w_cmd)
    );

    // datapath holds the bitmap, config and all arithmetic
    bpfa_dp #(
        .MAX_PAGES (MAX_PAGES),
        .PAGE_BYTES(PAGE_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_free_address(i_free_address),
        .i_rsp_ready   (i_rsp_ready),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_rsp_valid   (o_rsp_valid),
        .o_page_address(o_page_address),
        .o_status      (o_status)
    );

endmodule

@@ tb/bitmap_page_frame_allocator_tb.sv @@
// Self-checking testbench for the first-fit bitmap page frame allocator.
`timescale 1ns / 100ps

module bitmap_page_frame_allocator_tb
    import bpfa_pkg::*;
();

    localparam int MAX_PAGES  = 4096;
    localparam int PAGE_BYTES = 4096;

    // Index 3 has no register behind it; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Settle time after the final drain; ample margin over the longest scan.
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 1500000;

    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 90;

    typedef struct packed {
        logic [ADDR_W-1:0] page_address;
        t_status           status;
    } t_page_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_req_valid;
    logic                  o_req_ready;
    logic                  i_command;
    logic [ADDR_W-1:0]     i_free_address;
    logic                  o_rsp_valid;
    logic                  i_rsp_ready;
    logic [ADDR_W-1:0]     o_page_address;
    logic [1:0]            o_status;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predictor state: a mirror of the registers and of the used bits.
    logic [ADDR_W-1:0] mdl_base;
    logic [ADDR_W-1:0] mdl_offset;
    logic [PCNT_W-1:0] mdl_page_count;
    bit                page_used [MAX_PAGES];

    t_page_result pending_results [$];
    int unsigned  held_pages [$];      // indices handed out, candidates to free
    int unsigned  mismatches = 0;
    int unsigned  cycle_count = 0;

    bit          pace_en = 1'b0;       // random idling on both channels
    int unsigned rsp_hold_cycles = 0;  // one-shot long receiver hold-off

    bitmap_page_frame_allocator #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_req_valid),
        .o_req_ready    (o_req_ready),
        .i_command      (i_command),
        .i_free_address (i_free_address),
        .o_rsp_valid    (o_rsp_valid),
        .i_rsp_ready    (i_rsp_ready),
        .o_page_address (o_page_address),
        .o_status       (o_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit: a hung handshake ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("bitmap_page_frame_allocator verification failed");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly short idle stretches, now and then a long one.
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 90);
        return $urandom_range(1, 4);
    endfunction

    // Physical address of a page index under the current register values.
    function automatic logic [ADDR_W-1:0] page_addr(input int unsigned idx);
        return mdl_base + 64'(PAGE_BYTES) * 64'(idx) - mdl_offset;
    endfunction

    // First-fit allocate / free on the mirrored bitmap; queues the response.
    function automatic void predict_page_op(input logic cmd, input logic [ADDR_W-1:0] addr);
        t_page_result      res;
        int unsigned       lim;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] idx;
        bit                found;
        res.page_address = '0;
        res.status       = ST_OK;
        found            = 1'b0;
        // Counts above capacity are clipped to the bitmap size.
        lim = (int'(mdl_page_count) > MAX_PAGES) ? MAX_PAGES : int'(mdl_page_count);
        if (cmd == CMD_ALLOC) begin
            for (int unsigned i = 0; i < lim; i++) begin
                if (!page_used[i]) begin
                    page_used[i]     = 1'b1;
                    res.page_address = page_addr(i);
                    held_pages.push_back(i);
                    found            = 1'b1;
                    break;
                end
            end
            if (!found)
                res.status = ST_OOM;
        end else begin
            // Addresses below the region wrap to huge offsets and fall out of range.
            off = addr + mdl_offset - mdl_base;
            idx = off / 64'(PAGE_BYTES);
            if (idx < 64'(lim))
                page_used[idx] = 1'b0;
            else
                res.status = ST_RANGE;
        end
        pending_results.push_back(res);
    endfunction

    // Offer one request, hold it until taken, then maybe go idle.
    task automatic send_request(input logic cmd, input logic [ADDR_W-1:0] addr);
        int unsigned gap;
        i_req_valid    <= 1'b1;
        i_command      <= cmd;
        i_free_address <= addr;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        predict_page_op(cmd, addr);
        gap = 0;
        if (pace_en && $urandom_range(0, 2) != 0)
            gap = idle_len();
        if (gap != 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait for every outstanding response.
    task automatic drain();
        i_req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Register write, only ever issued with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_REGION_BASE:       mdl_base       = data;
            CFG_DIRECT_MAP_OFFSET: mdl_offset     = data;
            CFG_PAGE_COUNT:        mdl_page_count = data[PCNT_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Free a page handed out earlier, at a random byte inside it.
    task automatic free_held_page();
        int unsigned pick;
        int unsigned idx;
        pick = $urandom_range(0, held_pages.size() - 1);
        idx  = held_pages[pick];
        held_pages.delete(pick);
        send_request(CMD_FREE, page_addr(idx) + 64'($urandom_range(0, PAGE_BYTES - 1)));
    endtask

    // Receiver pacing: random stalls, plus a long hold-off on request.
    initial begin : rsp_pacing
        int unsigned n;
        i_rsp_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_hold_cycles != 0) begin
                n               = rsp_hold_cycles;
                rsp_hold_cycles = 0;
                i_rsp_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (pace_en && $urandom_range(0, 3) == 0) begin
                i_rsp_ready <= 1'b0;
                repeat (idle_len()) @(posedge i_clk);
            end
            i_rsp_ready <= 1'b1;
        end
    end

    // Response checker: every accepted response against the oldest prediction.
    always @(posedge i_clk) begin
        t_page_result exp_res;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected response, page_address %h status %0d",
                         $time, o_page_address, o_status);
                mismatches++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_page_address !== exp_res.page_address) begin
                    $display("%0t: page_address expected %h actual %h",
                             $time, exp_res.page_address, o_page_address);
                    mismatches++;
                end
                if (o_status !== exp_res.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_res.status, o_status);
                    mismatches++;
                end
            end
        end
    end

    // Zero page count right after reset, then each named corner in turn.
    task automatic test_directed_cases();
        pace_en = 1'b1;
        // Registers all zero after reset: nothing to hand out, nothing to free.
        send_request(CMD_ALLOC, '0);
        send_request(CMD_FREE, '0);

        // Classic direct map, physical = index * page size. The count write
        // carries junk above bit 12 that must be dropped.
        write_reg(CFG_REGION_BASE, 64'hFFFF_8000_0000_0000);
        write_reg(CFG_DIRECT_MAP_OFFSET, 64'hFFFF_8000_0000_0000);
        write_reg(CFG_PAGE_COUNT, 64'hFFFF_FFFF_FFFF_E003);
        repeat (4) send_request(CMD_ALLOC, '1);        // three pages, then out of memory
        send_request(CMD_FREE, page_addr(1) + 64'hABC); // unaligned, frees page 1
        send_request(CMD_FREE, page_addr(1));           // already free
        send_request(CMD_FREE, page_addr(0) - 64'd1);   // below region, wraps
        send_request(CMD_FREE, page_addr(3));           // first index past the count
        send_request(CMD_ALLOC, '0);                    // first fit takes page 1 again

        // Shrink: page 2 now sits above the count and cannot be freed.
        write_reg(CFG_PAGE_COUNT, 64'd1);
        send_request(CMD_FREE, page_addr(2));
        send_request(CMD_ALLOC, '0);

        // Count beyond capacity clips to the bitmap size.
        write_reg(CFG_PAGE_COUNT, 64'd8191);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_FREE, page_addr(2));
        send_request(CMD_ALLOC, '0);

        // Unmapped index is ignored; then the exact-capacity count.
        write_reg(CFG_UNUSED, '1);
        write_reg(CFG_PAGE_COUNT, 64'(MAX_PAGES));
        send_request(CMD_ALLOC, '0);

        // Region at the very top of the address space: addresses wrap.
        write_reg(CFG_REGION_BASE, 64'hFFFF_FFFF_FFFF_E000);
        write_reg(CFG_DIRECT_MAP_OFFSET, '0);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_FREE, page_addr(5) + 64'hFFF);

        // All-ones base and offset cancel out.
        write_reg(CFG_REGION_BASE, '1);
        write_reg(CFG_DIRECT_MAP_OFFSET, '1);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_FREE, '0);
        send_request(CMD_ALLOC, '0);

        write_reg(CFG_REGION_BASE, '0);
        write_reg(CFG_DIRECT_MAP_OFFSET, '0);
        send_request(CMD_FREE, '0);
        drain();
    endtask

    // Receiver stalls long enough to back the block up into its input,
    // the sender then waits out every response before a second burst.
    task automatic test_stalled_receiver();
        write_reg(CFG_PAGE_COUNT, 64'd40);
        pace_en         = 1'b0;
        rsp_hold_cycles = 400;
        repeat (12) begin
            if ($urandom_range(0, 3) != 0)
                send_request(CMD_ALLOC, rand64());
            else
                send_request(CMD_FREE, page_addr($urandom_range(0, 45)));
        end
        drain();
        repeat (8) begin
            if (held_pages.size() != 0 && $urandom_range(0, 1) == 0)
                free_held_page();
            else
                send_request(CMD_ALLOC, rand64());
        end
        drain();
    endtask

    // Phases of random setup and mostly well-formed alloc/free traffic.
    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] cnt;
        logic [ADDR_W-1:0]     base;
        int unsigned           r;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 5))
                0:       cnt = 64'($urandom_range(1, 8));
                1:       cnt = 64'($urandom_range(9, 70));
                2:       cnt = 64'($urandom_range(60, 300));
                3:       cnt = 64'(MAX_PAGES);
                4:       cnt = rand64();            // anything, junk upper bits
                default: cnt = ($urandom_range(0, 1) != 0) ? 64'd0 : 64'd8191;
            endcase
            // Now and then the count carries junk above the register width.
            if ($urandom_range(0, 3) == 0)
                cnt[CFG_DATA_W-1:PCNT_W] = (CFG_DATA_W - PCNT_W)'(rand64());
            base = rand64();
            write_reg(CFG_REGION_BASE, base);
            case ($urandom_range(0, 2))
                0:       write_reg(CFG_DIRECT_MAP_OFFSET, base);
                1:       write_reg(CFG_DIRECT_MAP_OFFSET, '0);
                default: write_reg(CFG_DIRECT_MAP_OFFSET, rand64());
            endcase
            write_reg(CFG_PAGE_COUNT, cnt);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, rand64());

            // First phase runs flat out on both sides.
            pace_en = (p != 0) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                r = $urandom_range(0, 99);
                if (r < 50)
                    send_request(CMD_ALLOC, rand64());
                else if (r < 85 && held_pages.size() != 0)
                    free_held_page();
                else if (r < 93)
                    send_request(CMD_FREE, rand64());
                else
                    // any index, past the count or already free included
                    send_request(CMD_FREE, page_addr($urandom_range(0, MAX_PAGES + 100))
                                           + 64'($urandom_range(0, PAGE_BYTES - 1)));
            end
            drain();
        end
    endtask

    initial begin : main_seq
        i_rst_n        <= 1'b0;
        i_req_valid    <= 1'b0;
        i_command      <= CMD_ALLOC;
        i_free_address <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= CFG_REGION_BASE;
        i_cfg_data     <= '0;
        mdl_base        = '0;
        mdl_offset      = '0;
        mdl_page_count  = '0;
        foreach (page_used[i]) page_used[i] = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Requests stall on o_req_ready through the post-reset clear.
        test_directed_cases();
        test_stalled_receiver();
        test_random_traffic();

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("bitmap_page_frame_allocator verification clean");
        else
            $display("bitmap_page_frame_allocator verification failed");
        $finish;
    end

endmodule
